// File: sv/pfc_pkg.sv
package pfc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned Lanes   = 4;

  localparam logic [2:0] CH_KEEP   = 3'd0;
  localparam logic [2:0] CH_GRAY   = 3'd1;
  localparam logic [2:0] CH_GRAY_A = 3'd2;
  localparam logic [2:0] CH_RGB    = 3'd3;
  localparam logic [2:0] CH_RGBA   = 3'd4;

  localparam logic DEPTH_8  = 1'b0;
  localparam logic DEPTH_16 = 1'b1;

  localparam logic [1:0] REG_SRC_CH    = 2'd0;
  localparam logic [1:0] REG_TGT_CH    = 2'd1;
  localparam logic [1:0] REG_SRC_DEPTH = 2'd2;
  localparam logic [1:0] REG_TGT_DEPTH = 2'd3;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    logic [2:0] src_ch;
    logic [2:0] tgt_ch;
    logic       src_depth;
    logic       tgt_depth;
  } pfc_cfg_t;

  typedef struct packed {
    sample_t [Lanes-1:0] smp;
    logic    [Lanes-1:0] keep;
  } pfc_mix_t;

endpackage

// File: sv/pfc_if.sv
interface pfc_in_if;
  logic               valid;
  logic               ready;
  pfc_pkg::sample_t   sample_zero;
  pfc_pkg::sample_t   sample_one;
  pfc_pkg::sample_t   sample_two;
  pfc_pkg::sample_t   sample_three;

  modport source (output valid, sample_zero, sample_one, sample_two, sample_three,
                  input ready);
  modport sink (input valid, sample_zero, sample_one, sample_two, sample_three,
                output ready);
endinterface

interface pfc_out_if;
  logic               valid;
  logic               ready;
  pfc_pkg::sample_t   result_zero;
  pfc_pkg::sample_t   result_one;
  pfc_pkg::sample_t   result_two;
  pfc_pkg::sample_t   result_three;

  modport source (output valid, result_zero, result_one, result_two, result_three,
                  input ready);
  modport sink (input valid, result_zero, result_one, result_two, result_three,
                output ready);
endinterface

// File: sv/pfc_cfg.sv
module pfc_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output pfc_pkg::pfc_cfg_t cfg
);

  logic [2:0] src_ch_r;
  logic [2:0] tgt_ch_r;
  logic       src_depth_r;
  logic       tgt_depth_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ch_r    <= pfc_pkg::CH_RGB;
      tgt_ch_r    <= pfc_pkg::CH_KEEP;
      src_depth_r <= pfc_pkg::DEPTH_8;
      tgt_depth_r <= pfc_pkg::DEPTH_8;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        pfc_pkg::REG_SRC_CH:    src_ch_r    <= pwdata[2:0];
        pfc_pkg::REG_TGT_CH:    tgt_ch_r    <= pwdata[2:0];
        pfc_pkg::REG_SRC_DEPTH: src_depth_r <= pwdata[0];
        pfc_pkg::REG_TGT_DEPTH: tgt_depth_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pfc_pkg::REG_SRC_CH:    prdata = {29'd0, src_ch_r};
      pfc_pkg::REG_TGT_CH:    prdata = {29'd0, tgt_ch_r};
      pfc_pkg::REG_SRC_DEPTH: prdata = {31'd0, src_depth_r};
      pfc_pkg::REG_TGT_DEPTH: prdata = {31'd0, tgt_depth_r};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg.src_ch    = src_ch_r;
  assign cfg.tgt_ch    = tgt_ch_r;
  assign cfg.src_depth = src_depth_r;
  assign cfg.tgt_depth = tgt_depth_r;

endmodule

// File: sv/pfc_chan_mix.sv
module pfc_chan_mix (
  input  pfc_pkg::pfc_cfg_t                       cfg,
  input  pfc_pkg::sample_t  [pfc_pkg::Lanes-1:0]  smp_in,
  output pfc_pkg::pfc_mix_t                       mix
);

  pfc_pkg::sample_t [pfc_pkg::Lanes-1:0] s;
  pfc_pkg::sample_t                      opaque;
  pfc_pkg::sample_t                      gray;
  logic [23:0]                           luma_sum;
  logic [2:0]                            from_c;
  logic [2:0]                            to_c;
  logic [2:0]                            cnt;
  logic                                  pass;
  logic                                  gray_src;

  always_comb begin
    for (int i = 0; i < pfc_pkg::Lanes; i++) begin
      s[i] = (cfg.src_depth == pfc_pkg::DEPTH_16) ? smp_in[i] : {8'd0, smp_in[i][7:0]};
    end
  end

  assign opaque = (cfg.src_depth == pfc_pkg::DEPTH_16) ? 16'hFFFF : 16'h00FF;

  assign from_c = (cfg.src_ch == pfc_pkg::CH_KEEP) ? pfc_pkg::CH_GRAY :
                  (cfg.src_ch > pfc_pkg::CH_RGBA) ? pfc_pkg::CH_RGBA : cfg.src_ch;
  assign to_c   = (cfg.tgt_ch > pfc_pkg::CH_RGBA) ? pfc_pkg::CH_KEEP : cfg.tgt_ch;
  assign pass   = (to_c == pfc_pkg::CH_KEEP) || (to_c == from_c);
  assign gray_src = (from_c == pfc_pkg::CH_GRAY) || (from_c == pfc_pkg::CH_GRAY_A);

  assign luma_sum = 24'(s[0]) * 24'd77 + 24'(s[1]) * 24'd150 + 24'(s[2]) * 24'd29;
  assign gray     = gray_src ? s[0] : luma_sum[23:8];

  always_comb begin
    mix.smp = '0;
    cnt     = to_c;
    if (pass) begin
      cnt     = from_c;
      mix.smp = s;
    end else begin
      case (to_c) inside
        pfc_pkg::CH_GRAY, pfc_pkg::CH_GRAY_A: begin
          mix.smp[0] = gray;
          if (to_c == pfc_pkg::CH_GRAY_A) begin
            mix.smp[1] = (from_c == pfc_pkg::CH_GRAY_A) ? s[1] :
                         (from_c == pfc_pkg::CH_RGBA)   ? s[3] : opaque;
          end
        end
        default: begin
          mix.smp[0] = s[0];
          mix.smp[1] = gray_src ? s[0] : s[1];
          mix.smp[2] = gray_src ? s[0] : s[2];
          if (to_c == pfc_pkg::CH_RGBA) begin
            mix.smp[3] = (from_c == pfc_pkg::CH_RGBA)   ? s[3] :
                         (from_c == pfc_pkg::CH_GRAY_A) ? s[1] : opaque;
          end
        end
      endcase
    end
    for (int i = 0; i < pfc_pkg::Lanes; i++) begin
      mix.keep[i] = (3'(i) < cnt);
    end
  end

endmodule

// File: sv/pfc_depth_lane.sv
module pfc_depth_lane (
  input  pfc_pkg::pfc_cfg_t cfg,
  input  pfc_pkg::sample_t  smp,
  input  logic              keep,
  output pfc_pkg::sample_t  res
);

  logic [23:0] scaled;
  logic [24:0] quot_sum;

  // x*255 + 32767, then divide by 65535 as (y + (y >> 16) + 1) >> 16
  assign scaled   = {smp, 8'd0} - 24'(smp) + 24'd32767;
  assign quot_sum = 25'(scaled) + 25'(scaled[23:16]) + 25'd1;

  always_comb begin
    if (!keep) begin
      res = '0;
    end else if (cfg.src_depth == cfg.tgt_depth) begin
      res = smp;
    end else if (cfg.tgt_depth == pfc_pkg::DEPTH_16) begin
      res = {smp[7:0], 8'd0} + {8'd0, smp[7:0]};
    end else begin
      res = {8'd0, quot_sum[23:16]};
    end
  end

endmodule

// File: sv/pixel_format_converter.sv
// Accepted input words pass the mix register, then the output register.
// Throughput: one pixel per cycle unless out_chan.ready stalls; channel mix
// stage feeds four depth lanes, whose results land in the output register.
// Reset (synchronous, rst_n low): pipeline empties; registers return to
// RGB source, keep-count target, 8-bit source and target depth.
module pixel_format_converter (
  input  logic       clk,
  input  logic       rst_n,
  pfc_in_if.sink     in_chan,
  pfc_out_if.source  out_chan,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic       cfg_pready
);

  pfc_pkg::pfc_cfg_t                       cfg;
  pfc_pkg::sample_t  [pfc_pkg::Lanes-1:0]  smp_in;
  pfc_pkg::pfc_mix_t                       mix_nxt;
  pfc_pkg::pfc_mix_t                       mix_r;
  pfc_pkg::sample_t  [pfc_pkg::Lanes-1:0]  lane_res;
  pfc_pkg::sample_t  [pfc_pkg::Lanes-1:0]  res_r;
  logic                                    mix_v_r;
  logic                                    res_v_r;
  logic                                    mix_take;
  logic                                    res_take;

  pfc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign smp_in[0] = in_chan.sample_zero;
  assign smp_in[1] = in_chan.sample_one;
  assign smp_in[2] = in_chan.sample_two;
  assign smp_in[3] = in_chan.sample_three;

  pfc_chan_mix u_mix (
    .cfg    (cfg),
    .smp_in (smp_in),
    .mix    (mix_nxt)
  );

  for (genvar g = 0; g < pfc_pkg::Lanes; g++) begin : g_lane
    pfc_depth_lane u_lane (
      .cfg  (cfg),
      .smp  (mix_r.smp[g]),
      .keep (mix_r.keep[g]),
      .res  (lane_res[g])
    );
  end

  assign res_take      = !res_v_r || out_chan.ready;
  assign mix_take      = !mix_v_r || res_take;
  assign in_chan.ready = mix_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (mix_take) begin
        mix_v_r <= in_chan.valid;
      end
      if (res_take) begin
        res_v_r <= mix_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mix_take && in_chan.valid) begin
      mix_r <= mix_nxt;
    end
    if (res_take && mix_v_r) begin
      res_r <= lane_res;
    end
  end

  assign out_chan.valid        = res_v_r;
  assign out_chan.result_zero  = res_r[0];
  assign out_chan.result_one   = res_r[1];
  assign out_chan.result_two   = res_r[2];
  assign out_chan.result_three = res_r[3];

endmodule

// File: tb/tb_top.sv
module tb_top;

  typedef pfc_pkg::sample_t [pfc_pkg::Lanes-1:0] quad_t;

  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pfc_in_if  in_if ();
  pfc_out_if out_if ();

  pixel_format_converter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  logic [2:0] fmt_src_ch    = pfc_pkg::CH_RGB;
  logic [2:0] fmt_tgt_ch    = pfc_pkg::CH_KEEP;
  logic       fmt_src_depth = pfc_pkg::DEPTH_8;
  logic       fmt_tgt_depth = pfc_pkg::DEPTH_8;

  quad_t pixel_q[$];
  quad_t converted_q[$];
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  bit    hold_trig = 1'b0;
  int    hold_left = 0;
  int    mismatches = 0;
  int    idle_cycles = 0;
  quad_t want;
  quad_t got;
  string lane_name[pfc_pkg::Lanes] = '{"result_zero", "result_one", "result_two",
                                       "result_three"};

  function automatic pfc_pkg::sample_t rescale(pfc_pkg::sample_t x);
    if (fmt_src_depth == fmt_tgt_depth) return x;
    if (fmt_tgt_depth == pfc_pkg::DEPTH_16) return pfc_pkg::sample_t'(32'(x) * 257);
    return pfc_pkg::sample_t'((32'(x) * 255 + 32767) / 65535);
  endfunction

  function automatic quad_t convert_pixel(quad_t px);
    quad_t            s;
    quad_t            d;
    quad_t            res;
    pfc_pkg::sample_t opaque;
    logic [2:0]       from;
    logic [2:0]       to;
    logic [2:0]       count;
    logic [31:0]      y;
    opaque = (fmt_src_depth == pfc_pkg::DEPTH_16) ? 16'hFFFF : 16'h00FF;
    for (int i = 0; i < pfc_pkg::Lanes; i++) s[i] = px[i] & opaque;
    from = (fmt_src_ch == pfc_pkg::CH_KEEP) ? pfc_pkg::CH_GRAY :
           (fmt_src_ch > pfc_pkg::CH_RGBA)  ? pfc_pkg::CH_RGBA : fmt_src_ch;
    to = (fmt_tgt_ch > pfc_pkg::CH_RGBA) ? pfc_pkg::CH_KEEP : fmt_tgt_ch;
    y = (32'(s[0]) * 77 + 32'(s[1]) * 150 + 32'(s[2]) * 29) >> 8;
    d = '0;
    if (to == pfc_pkg::CH_KEEP || to == from) begin
      count = from;
      d = s;
    end else begin
      count = to;
      if (to == pfc_pkg::CH_GRAY || to == pfc_pkg::CH_GRAY_A) begin
        d[0] = (from <= pfc_pkg::CH_GRAY_A) ? s[0] : pfc_pkg::sample_t'(y);
        if (to == pfc_pkg::CH_GRAY_A)
          d[1] = (from == pfc_pkg::CH_GRAY_A) ? s[1] :
                 (from == pfc_pkg::CH_RGBA)   ? s[3] : opaque;
      end else begin
        if (from <= pfc_pkg::CH_GRAY_A) begin
          d[0] = s[0]; d[1] = s[0]; d[2] = s[0];
        end else begin
          d[0] = s[0]; d[1] = s[1]; d[2] = s[2];
        end
        if (to == pfc_pkg::CH_RGBA)
          d[3] = (from == pfc_pkg::CH_RGBA)   ? s[3] :
                 (from == pfc_pkg::CH_GRAY_A) ? s[1] : opaque;
      end
    end
    for (int i = 0; i < pfc_pkg::Lanes; i++) res[i] = (i < count) ? rescale(d[i]) : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        converted_q.push_back(convert_pixel({in_if.sample_three, in_if.sample_two,
                                             in_if.sample_one, in_if.sample_zero}));
      if (!in_if.valid || in_if.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.sample_zero  <= pixel_q[0][0];
          in_if.sample_one   <= pixel_q[0][1];
          in_if.sample_two   <= pixel_q[0][2];
          in_if.sample_three <= pixel_q[0][3];
          void'(pixel_q.pop_front());
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.result_three, out_if.result_two, out_if.result_one, out_if.result_zero};
        if (converted_q.size() == 0) begin
          $error("unexpected word %h", got);
          mismatches++;
        end else begin
          want = converted_q.pop_front();
          for (int i = 0; i < pfc_pkg::Lanes; i++)
            if (got[i] !== want[i]) begin
              $error("%s: expected %h, got %h", lane_name[i], want[i], got[i]);
              mismatches++;
            end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_trig) begin
        hold_trig = 1'b0;
        hold_left = HoldCycles;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {29'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_format(logic [2:0] src, logic [2:0] tgt, logic sd, logic td);
    write_reg(pfc_pkg::REG_SRC_CH, src);
    write_reg(pfc_pkg::REG_TGT_CH, tgt);
    write_reg(pfc_pkg::REG_SRC_DEPTH, {2'b00, sd});
    write_reg(pfc_pkg::REG_TGT_DEPTH, {2'b00, td});
    fmt_src_ch    = src;
    fmt_tgt_ch    = tgt;
    fmt_src_depth = sd;
    fmt_tgt_depth = td;
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || in_if.valid || converted_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_pixel(pfc_pkg::sample_t s0, pfc_pkg::sample_t s1,
                            pfc_pkg::sample_t s2, pfc_pkg::sample_t s3);
    pixel_q.push_back({s3, s2, s1, s0});
  endtask

  function automatic pfc_pkg::sample_t random_sample();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h00FF;
      3: return 16'hFF00;
      default: return pfc_pkg::sample_t'($urandom);
    endcase
  endfunction

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.sample_zero  = '0;
    in_if.sample_one   = '0;
    in_if.sample_two   = '0;
    in_if.sample_three = '0;
    out_if.ready       = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 74;
    push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_pixel(16'h12FF, 16'hAB80, 16'h0001, 16'h5555);
    drain();

    set_format(pfc_pkg::CH_RGBA, pfc_pkg::CH_GRAY, pfc_pkg::DEPTH_16, pfc_pkg::DEPTH_8);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_pixel(16'h8000, 16'h0080, 16'h7FFF, 16'hFFFF);
    push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain();
    set_format(pfc_pkg::CH_GRAY, pfc_pkg::CH_RGBA, pfc_pkg::DEPTH_8, pfc_pkg::DEPTH_16);
    push_pixel(16'hFF00, 16'h1234, 16'h5678, 16'h9ABC);
    push_pixel(16'h00FF, 16'h0000, 16'h0000, 16'h0000);
    push_pixel(16'h0080, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    set_format(pfc_pkg::CH_GRAY_A, pfc_pkg::CH_RGBA, pfc_pkg::DEPTH_16, pfc_pkg::DEPTH_16);
    push_pixel(16'hA5A5, 16'h5A5A, 16'hFFFF, 16'hFFFF);
    push_pixel(16'hFFFF, 16'h0000, 16'h1111, 16'h2222);
    drain();
    set_format(pfc_pkg::CH_RGBA, pfc_pkg::CH_GRAY_A, pfc_pkg::DEPTH_16, pfc_pkg::DEPTH_8);
    push_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0080);
    drain();
    set_format(3'd0, 3'd7, pfc_pkg::DEPTH_8, pfc_pkg::DEPTH_16);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_pixel(16'h0001, 16'h0002, 16'h0003, 16'h0004);
    drain();
    set_format(3'd7, pfc_pkg::CH_RGB, pfc_pkg::DEPTH_16, pfc_pkg::DEPTH_16);
    push_pixel(16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE);
    push_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    drain();
    set_format(pfc_pkg::CH_RGB, pfc_pkg::CH_GRAY_A, pfc_pkg::DEPTH_8, pfc_pkg::DEPTH_8);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_pixel(16'h0180, 16'h0240, 16'h0320, 16'h1234);
    drain();
    set_format(pfc_pkg::CH_GRAY_A, pfc_pkg::CH_RGB, pfc_pkg::DEPTH_8, pfc_pkg::DEPTH_16);
    push_pixel(16'hFFFF, 16'h00FF, 16'h0000, 16'h0000);
    push_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 36; ph++) begin
      if (ph == 12) begin
        send_idle_pct = 74;
        recv_idle_pct = 10;
      end else if (ph == 24) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_format(($urandom_range(9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7)),
                 ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (ph == 3 || ph == 27) hold_trig = 1'b1;
      repeat (29) push_pixel(random_sample(), random_sample(), random_sample(), random_sample());
      drain();
    end

    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
